// ===== hw/rtl/moving_circle_collision_time_core_assert.svh =====
// Assertion macros for the collision time core top level.
`ifndef MOVING_CIRCLE_COLLISION_TIME_CORE_ASSERT_SVH
`define MOVING_CIRCLE_COLLISION_TIME_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MCCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define MCCT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define MCCT_ASSERT(lbl, prop, msg)
`define MCCT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hw/rtl/mcct_pkg.sv =====
// Shared constants and types for the moving circle collision time core.
`timescale 1ns / 1ps
package mcct_pkg;

    localparam int KIND_W   = 2;
    localparam logic [KIND_W-1:0] KIND_TIME  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ZERO  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NOHIT = 2'd2;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL    = 1'd1;
    localparam int CFG_DATA_W = 16;

    localparam int BASE_W   = 33;
    localparam int DVSR_W   = 34;
    localparam int NUM_W    = 49;
    localparam int QUO_W    = 32;
    localparam int RAD_W    = 66;
    localparam int ROOT_W   = 49;
    localparam int REM_W    = ROOT_W + 4;
    localparam int SQ_STEPS = ROOT_W;
    localparam int DV_STEPS = QUO_W;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BASE_W-1:0] base;
        logic [DVSR_W-1:0] dvsr;
    } t_sq_side;

endpackage

// ===== hw/rtl/mcct_in_if.sv =====
// Input channel carrying one pair of circles.
`timescale 1ns / 1ps
interface mcct_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
    logic signed [15:0] first_vel_x;
    logic signed [15:0] first_vel_y;
    logic signed [15:0] second_vel_x;
    logic signed [15:0] second_vel_y;
    logic        [11:0] first_radius;
    logic        [11:0] second_radius;

    modport source (
        output valid, first_x, first_y, second_x, second_y, first_vel_x, first_vel_y,
               second_vel_x, second_vel_y, first_radius, second_radius,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, second_x, second_y, first_vel_x, first_vel_y,
               second_vel_x, second_vel_y, first_radius, second_radius,
        output ready
    );
endinterface

// ===== hw/rtl/mcct_out_if.sv =====
// Output channel carrying one contact time result.
`timescale 1ns / 1ps
interface mcct_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hit_time;
    logic        no_hit;
    logic        saturated;

    modport source (output valid, hit_time, no_hit, saturated, input ready);
    modport sink (input valid, hit_time, no_hit, saturated, output ready);
endinterface

// ===== hw/rtl/moving_circle_collision_time_core.sv =====
// Top level of the moving circle collision time core.
// Each transaction on i_in_ch carries two circles (center, velocity, radius);
// each produces exactly one transaction on o_out_ch with the earliest contact
// time in unsigned Q16.16, a no_hit flag and a saturated flag.
// Configuration: while no transaction is in flight, write overlap_margin
// (index 0) or zero_tolerance (index 1) through i_cfg_we/i_cfg_idx/i_cfg_data.
// A transaction passes five arithmetic stages, 49 square root stages (one
// root bit each), one subtract stage, 33 divider stages (overflow check and
// one quotient bit each) and the output register before its result is valid.
// Throughput is one transaction per cycle while the output is not held.
// All stages advance together whenever the output register is empty or is
// being taken; while the receiver holds ready low with a result waiting, the
// whole pipeline and i_in_ch.ready hold, and no data is lost or repeated.
// Synchronous reset empties the pipeline and clears both configuration
// registers to zero; the block takes transactions in the cycle after reset.
`timescale 1ns / 1ps
`include "moving_circle_collision_time_core_assert.svh"
module moving_circle_collision_time_core
    import mcct_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    mcct_in_if.sink               i_in_ch,
    mcct_out_if.source            o_out_ch
);

    logic [15:0] r_margin;
    logic [15:0] r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= '0;
            r_tol    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MARGIN: r_margin <= i_cfg_data;
                CFG_TOL:    r_tol    <= i_cfg_data;
                default:    r_tol    <= r_tol;
            endcase
        end
    end

    logic w_adv;
    logic r_out_vld;

    assign w_adv         = !r_out_vld || o_out_ch.ready;
    assign i_in_ch.ready = w_adv;

    // Stage 1: relative position, relative velocity, radius sum.
    logic signed [16:0] r1_dpx, r1_dpy, r1_dvx, r1_dvy;
    logic        [12:0] r1_rs;
    logic               r1_vld;

    // Stage 2: products.
    logic signed [33:0] n2_pvx, n2_pvy, n2_sqvx, n2_sqvy, n2_sqpx, n2_sqpy;
    logic signed [33:0] r2_pvx, r2_pvy;
    logic        [31:0] r2_vvx, r2_vvy, r2_ppx, r2_ppy;
    logic        [25:0] r2_rr;
    logic               r2_vld;

    assign n2_pvx  = 34'(r1_dpx) * 34'(r1_dvx);
    assign n2_pvy  = 34'(r1_dpy) * 34'(r1_dvy);
    assign n2_sqvx = 34'(r1_dvx) * 34'(r1_dvx);
    assign n2_sqvy = 34'(r1_dvy) * 34'(r1_dvy);
    assign n2_sqpx = 34'(r1_dpx) * 34'(r1_dpx);
    assign n2_sqpy = 34'(r1_dpy) * 34'(r1_dpy);

    // Stage 3: quadratic coefficients a, h = b/2, c and |h|.
    logic        [32:0] n3_a;
    logic signed [33:0] n3_h;
    logic signed [33:0] n3_habs_full;
    logic        [32:0] n3_pp;
    logic signed [34:0] n3_c;
    logic        [32:0] r3_a;
    logic        [32:0] r3_habs;
    logic               r3_hneg;
    logic signed [34:0] r3_c;
    logic               r3_vld;

    always_comb begin
        n3_a         = {1'b0, r2_vvx} + {1'b0, r2_vvy};
        n3_h         = r2_pvx + r2_pvy;
        n3_habs_full = n3_h[33] ? -n3_h : n3_h;
        n3_pp        = {1'b0, r2_ppx} + {1'b0, r2_ppy};
        n3_c         = $signed({2'b00, n3_pp}) - $signed({9'd0, r2_rr});
    end

    // Stage 4: case selection and the discriminant products.
    logic               n4_azero, n4_bzero, n4_cle;
    logic [KIND_W-1:0]  n4_kind;
    logic               n4_lin, n4_quad;
    logic [65:0]        n4_hsq, n4_ac;
    logic [65:0]        r4_hsq, r4_ac;
    logic [KIND_W-1:0]  r4_kind;
    logic               r4_quad;
    logic [BASE_W-1:0]  r4_base;
    logic [DVSR_W-1:0]  r4_dvsr;
    logic               r4_vld;

    always_comb begin
        n4_azero = (r3_a <= {17'd0, r_tol});
        n4_bzero = ({r3_habs, 1'b0} <= {18'd0, r_tol});
        n4_cle   = (r3_c <= $signed({19'd0, r_margin}));
        n4_lin   = 1'b0;
        n4_quad  = 1'b0;
        priority if (n4_cle) begin
            n4_kind = KIND_ZERO;
        end else if (n4_azero && !n4_bzero) begin
            // A positive b means the gap only grows.
            n4_kind = r3_hneg ? KIND_TIME : KIND_NOHIT;
            n4_lin  = r3_hneg;
        end else if (n4_azero) begin
            n4_kind = KIND_NOHIT;
        end else if (!r3_hneg) begin
            n4_kind = KIND_NOHIT;
        end else begin
            n4_kind = KIND_TIME;
            n4_quad = 1'b1;
        end
        n4_hsq = 66'(r3_habs) * 66'(r3_habs);
        n4_ac  = 66'(r3_a) * 66'(r3_c[32:0]);
    end

    // Stage 5: discriminant and its sign.
    logic               n5_neg;
    logic [RAD_W-1:0]   r5_rad;
    t_sq_side           r5_side;
    logic               r5_vld;

    assign n5_neg = r4_quad && (r4_ac > r4_hsq);

    // Square root of the discriminant times 2^32.
    logic               w_sq_vld;
    logic [ROOT_W-1:0]  w_sq_root;
    t_sq_side           w_sq_side;

    mcct_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (r5_vld),
        .i_rad   (r5_rad),
        .i_side  (r5_side),
        .o_vld   (w_sq_vld),
        .o_root  (w_sq_root),
        .o_side  (w_sq_side)
    );

    // Stage 6: numerator. The linear case goes through with a zero root.
    logic [NUM_W-1:0]   r6_num;
    logic [DVSR_W-1:0]  r6_dvsr;
    logic [KIND_W-1:0]  r6_kind;
    logic               r6_vld;

    logic               w_dv_vld;
    logic [QUO_W-1:0]   w_dv_quo;
    logic               w_dv_ovf;
    logic [KIND_W-1:0]  w_dv_kind;

    mcct_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (r6_vld),
        .i_num   (r6_num),
        .i_dvsr  (r6_dvsr),
        .i_kind  (r6_kind),
        .o_vld   (w_dv_vld),
        .o_quo   (w_dv_quo),
        .o_ovf   (w_dv_ovf),
        .o_kind  (w_dv_kind)
    );

    // Output register.
    logic [QUO_W-1:0] r_out_time;
    logic             r_out_nohit;
    logic             r_out_sat;
    logic [QUO_W-1:0] n_out_time;
    logic             n_out_nohit;
    logic             n_out_sat;

    always_comb begin
        n_out_time  = w_dv_quo;
        n_out_nohit = 1'b0;
        n_out_sat   = 1'b0;
        unique case (w_dv_kind)
            KIND_ZERO: begin
                n_out_time = '0;
            end
            KIND_NOHIT: begin
                n_out_time  = '1;
                n_out_nohit = 1'b1;
            end
            KIND_TIME: begin
                if (w_dv_ovf) begin
                    n_out_time = '1;
                    n_out_sat  = 1'b1;
                end
            end
            default: begin
                n_out_time  = '1;
                n_out_nohit = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r5_vld    <= 1'b0;
            r6_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r1_vld    <= i_in_ch.valid;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r4_vld    <= r3_vld;
            r5_vld    <= r4_vld;
            r6_vld    <= w_sq_vld;
            r_out_vld <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_dpx <= 17'(i_in_ch.first_x) - 17'(i_in_ch.second_x);
            r1_dpy <= 17'(i_in_ch.first_y) - 17'(i_in_ch.second_y);
            r1_dvx <= 17'(i_in_ch.first_vel_x) - 17'(i_in_ch.second_vel_x);
            r1_dvy <= 17'(i_in_ch.first_vel_y) - 17'(i_in_ch.second_vel_y);
            r1_rs  <= {1'b0, i_in_ch.first_radius} + {1'b0, i_in_ch.second_radius};

            r2_pvx <= n2_pvx;
            r2_pvy <= n2_pvy;
            r2_vvx <= n2_sqvx[31:0];
            r2_vvy <= n2_sqvy[31:0];
            r2_ppx <= n2_sqpx[31:0];
            r2_ppy <= n2_sqpy[31:0];
            r2_rr  <= 26'(r1_rs) * 26'(r1_rs);

            r3_a    <= n3_a;
            r3_habs <= n3_habs_full[32:0];
            r3_hneg <= n3_h[33];
            r3_c    <= n3_c;

            r4_hsq  <= n4_hsq;
            r4_ac   <= n4_ac;
            r4_kind <= n4_kind;
            r4_quad <= n4_quad;
            r4_base <= n4_lin ? r3_c[32:0] : r3_habs;
            r4_dvsr <= n4_lin ? {r3_habs, 1'b0} : {1'b0, r3_a};

            r5_rad       <= (r4_quad && !n5_neg) ? (r4_hsq - r4_ac) : '0;
            r5_side.kind <= n5_neg ? KIND_NOHIT : r4_kind;
            r5_side.base <= r4_base;
            r5_side.dvsr <= r4_dvsr;

            r6_num  <= {w_sq_side.base, 16'd0} - w_sq_root;
            r6_dvsr <= w_sq_side.dvsr;
            r6_kind <= w_sq_side.kind;

            r_out_time  <= n_out_time;
            r_out_nohit <= n_out_nohit;
            r_out_sat   <= n_out_sat;
        end
    end

    assign o_out_ch.valid     = r_out_vld;
    assign o_out_ch.hit_time  = r_out_time;
    assign o_out_ch.no_hit    = r_out_nohit;
    assign o_out_ch.saturated = r_out_sat;

    `MCCT_ASSERT(a_flags_exclusive, o_out_ch.valid |-> !(o_out_ch.no_hit && o_out_ch.saturated), "no_hit and saturated both set")
    `MCCT_ASSERT(a_nohit_time, (o_out_ch.valid && o_out_ch.no_hit) |-> (o_out_ch.hit_time == '1), "no_hit without all-ones time")
    `MCCT_ASSERT(a_sat_time, (o_out_ch.valid && o_out_ch.saturated) |-> (o_out_ch.hit_time == '1), "saturated without all-ones time")
    `MCCT_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_ch.valid, "result valid right after reset")

endmodule

// ===== hw/rtl/mcct_sqrt.sv =====
// Pipelined integer square root of the discriminant scaled by 2^32, one bit per stage.
`timescale 1ns / 1ps
module mcct_sqrt
    import mcct_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [RAD_W-1:0]  i_rad,
    input  t_sq_side          i_side,
    output logic              o_vld,
    output logic [ROOT_W-1:0] o_root,
    output t_sq_side          o_side
);

    logic [REM_W-1:0]  r_rem  [SQ_STEPS];
    logic [ROOT_W-1:0] r_root [SQ_STEPS];
    logic [RAD_W-1:0]  r_rad  [SQ_STEPS];
    logic              r_vld  [SQ_STEPS];
    t_sq_side          r_side [SQ_STEPS];

    genvar k;
    generate
        for (k = 0; k < SQ_STEPS; k++) begin : g_step
            logic [REM_W-1:0]  p_rem;
            logic [ROOT_W-1:0] p_root;
            logic [RAD_W-1:0]  p_rad;
            logic              p_vld;
            t_sq_side          p_side;
            logic [REM_W-1:0]  cur;
            logic [REM_W-1:0]  trial;
            logic              ge;

            if (k == 0) begin : g_first
                assign p_rem  = '0;
                assign p_root = '0;
                assign p_rad  = i_rad;
                assign p_vld  = i_vld;
                assign p_side = i_side;
            end else begin : g_next
                assign p_rem  = r_rem[k-1];
                assign p_root = r_root[k-1];
                assign p_rad  = r_rad[k-1];
                assign p_vld  = r_vld[k-1];
                assign p_side = r_side[k-1];
            end

            // Bring down the next pair of radicand bits and try root*4+1.
            always_comb begin
                cur   = {p_rem[REM_W-3:0], p_rad[RAD_W-1:RAD_W-2]};
                trial = {2'b00, p_root, 2'b01};
                ge    = (cur >= trial);
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= p_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k]  <= ge ? (cur - trial) : cur;
                    r_root[k] <= {p_root[ROOT_W-2:0], ge};
                    r_rad[k]  <= {p_rad[RAD_W-3:0], 2'b00};
                    r_side[k] <= p_side;
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[SQ_STEPS-1];
    assign o_root = r_root[SQ_STEPS-1];
    assign o_side = r_side[SQ_STEPS-1];

endmodule

// ===== hw/rtl/mcct_div.sv =====
// Pipelined restoring divider giving a 32-bit quotient and an overflow flag.
`timescale 1ns / 1ps
module mcct_div
    import mcct_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DVSR_W-1:0] i_dvsr,
    input  logic [KIND_W-1:0] i_kind,
    output logic              o_vld,
    output logic [QUO_W-1:0]  o_quo,
    output logic              o_ovf,
    output logic [KIND_W-1:0] o_kind
);

    localparam int HI_W = NUM_W - QUO_W;

    logic [DVSR_W-1:0] r_rem  [DV_STEPS+1];
    logic [QUO_W-1:0]  r_low  [DV_STEPS+1];
    logic [DVSR_W-1:0] r_dvsr [DV_STEPS+1];
    logic [KIND_W-1:0] r_kind [DV_STEPS+1];
    logic              r_ovf  [DV_STEPS+1];
    logic              r_vld  [DV_STEPS+1];

    // The quotient fits in 32 bits only when the upper dividend bits are below the divisor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0]  <= ({{(DVSR_W-HI_W){1'b0}}, i_num[NUM_W-1:QUO_W]} >= i_dvsr);
            r_rem[0]  <= {{(DVSR_W-HI_W){1'b0}}, i_num[NUM_W-1:QUO_W]};
            r_low[0]  <= i_num[QUO_W-1:0];
            r_dvsr[0] <= i_dvsr;
            r_kind[0] <= i_kind;
        end
    end

    genvar k;
    generate
        for (k = 0; k < DV_STEPS; k++) begin : g_step
            logic [DVSR_W:0] cur;
            logic [DVSR_W:0] diff;
            logic            ge;

            always_comb begin
                cur  = {r_rem[k], r_low[k][QUO_W-1]};
                diff = cur - {1'b0, r_dvsr[k]};
                ge   = (cur >= {1'b0, r_dvsr[k]});
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k+1] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k+1] <= r_vld[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1]  <= ge ? diff[DVSR_W-1:0] : cur[DVSR_W-1:0];
                    r_low[k+1]  <= {r_low[k][QUO_W-2:0], ge};
                    r_dvsr[k+1] <= r_dvsr[k];
                    r_kind[k+1] <= r_kind[k];
                    r_ovf[k+1]  <= r_ovf[k];
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[DV_STEPS];
    assign o_quo  = r_low[DV_STEPS];
    assign o_ovf  = r_ovf[DV_STEPS];
    assign o_kind = r_kind[DV_STEPS];

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the moving circle collision time core.
`timescale 1ns / 1ps
module tb;
    import mcct_pkg::*;

    typedef struct packed {
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] fvx;
        logic signed [15:0] fvy;
        logic signed [15:0] svx;
        logic signed [15:0] svy;
        logic        [11:0] fr;
        logic        [11:0] sr;
    } circle_pair_t;

    typedef struct packed {
        logic [31:0] hit_time;
        logic        no_hit;
        logic        saturated;
    } contact_t;

    typedef struct packed {
        circle_pair_t pair;
        logic [15:0]  margin;
        logic [15:0]  tol;
        logic         known;
        contact_t     result;
    } stim_row_t;

    localparam contact_t NEVER    = '{32'hFFFF_FFFF, 1'b1, 1'b0};
    localparam contact_t TOUCHING = '{32'd0, 1'b0, 1'b0};
    localparam longint   LIMIT    = 2_000_000;
    localparam int       DRAIN    = 120;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_MARGIN;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    mcct_in_if  in_ch ();
    mcct_out_if out_ch ();

    moving_circle_collision_time_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch)
    );

    always #6 i_clk = ~i_clk;

    logic [15:0] cur_margin = '0;
    logic [15:0] cur_tol = '0;
    contact_t    expected_contacts[$];
    stim_row_t   directed_rows[$];
    longint      cycle_count = 0;
    int          mismatch_count = 0;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.first_x = '0;
        in_ch.first_y = '0;
        in_ch.second_x = '0;
        in_ch.second_y = '0;
        in_ch.first_vel_x = '0;
        in_ch.first_vel_y = '0;
        in_ch.second_vel_x = '0;
        in_ch.second_vel_y = '0;
        in_ch.first_radius = '0;
        in_ch.second_radius = '0;
        out_ch.ready = 1'b0;
    end

    // Idling is switched off for a long stretch in the middle of the run.
    function automatic bit take_break();
        return (cycle_count < 1500 || cycle_count >= 3000) && ($urandom_range(0, 99) < 10);
    endfunction

    function automatic contact_t predict_contact(circle_pair_t p);
        longint dpx, dpy, dvx, dvy, rs, a, h, b, c, absb;
        logic [127:0] hsq, ac, disc, cand_sq;
        logic [63:0]  root, cand, mh, quot;
        contact_t     res;
        dpx = longint'(p.fx) - longint'(p.sx);
        dpy = longint'(p.fy) - longint'(p.sy);
        dvx = longint'(p.fvx) - longint'(p.svx);
        dvy = longint'(p.fvy) - longint'(p.svy);
        rs = longint'(p.fr) + longint'(p.sr);
        a = dvx * dvx + dvy * dvy;
        h = dpx * dvx + dpy * dvy;
        b = 2 * h;
        c = dpx * dpx + dpy * dpy - rs * rs;
        absb = (b < 0) ? -b : b;
        if (c <= longint'(cur_margin))
            return TOUCHING;
        if (a <= longint'(cur_tol)) begin
            if (absb <= longint'(cur_tol) || b > 0)
                return NEVER;
            quot = (64'(c) << 16) / 64'(-b);
        end else begin
            if (h >= 0)
                return NEVER;
            mh = 64'(-h);
            hsq = 128'(mh) * 128'(mh);
            ac = 128'(64'(a)) * 128'(64'(c));
            if (ac > hsq)
                return NEVER;
            disc = (hsq - ac) << 32;
            root = '0;
            for (int k = 56; k >= 0; k--) begin
                cand = root | (64'd1 << k);
                cand_sq = 128'(cand) * 128'(cand);
                if (cand_sq <= disc)
                    root = cand;
            end
            quot = ((mh << 16) - root) / 64'(a);
        end
        if (quot > 64'hFFFF_FFFF) begin
            res = '{32'hFFFF_FFFF, 1'b0, 1'b1};
        end else begin
            res = '{quot[31:0], 1'b0, 1'b0};
        end
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        contact_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_contacts.size() == 0) begin
                report_mismatch("result with no transaction outstanding");
            end else begin
                want = expected_contacts.pop_front();
                if (out_ch.hit_time !== want.hit_time)
                    report_mismatch($sformatf("hit_time %h, expected %h",
                        out_ch.hit_time, want.hit_time));
                if (out_ch.no_hit !== want.no_hit)
                    report_mismatch($sformatf("no_hit %b, expected %b",
                        out_ch.no_hit, want.no_hit));
                if (out_ch.saturated !== want.saturated)
                    report_mismatch($sformatf("saturated %b, expected %b",
                        out_ch.saturated, want.saturated));
            end
        end
    end

    // Receiver side stalls at random.
    always @(posedge i_clk) begin
        out_ch.ready <= i_rst_n && !take_break();
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    // Registers change only once the pipeline has drained.
    task automatic set_config(logic [15:0] margin, logic [15:0] tol);
        while (expected_contacts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        write_reg(CFG_MARGIN, margin);
        write_reg(CFG_TOL, tol);
        i_cfg_we <= 1'b0;
        cur_margin = margin;
        cur_tol = tol;
    endtask

    task automatic send_pair(circle_pair_t p, bit known, contact_t result);
        while (take_break()) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.first_x <= p.fx;
        in_ch.first_y <= p.fy;
        in_ch.second_x <= p.sx;
        in_ch.second_y <= p.sy;
        in_ch.first_vel_x <= p.fvx;
        in_ch.first_vel_y <= p.fvy;
        in_ch.second_vel_x <= p.svx;
        in_ch.second_vel_y <= p.svy;
        in_ch.first_radius <= p.fr;
        in_ch.second_radius <= p.sr;
        do @(posedge i_clk); while (!in_ch.ready);
        expected_contacts = {expected_contacts, (known ? result : predict_contact(p))};
    endtask

    task automatic add_row(circle_pair_t p, logic [15:0] margin, logic [15:0] tol,
                           bit known, contact_t result);
        stim_row_t new_row;
        new_row = '{p, margin, tol, known, result};
        directed_rows = {directed_rows, new_row};
    endtask

    function automatic logic signed [15:0] rand16();
        return 16'($urandom);
    endfunction

    // Mostly pairs heading toward each other, so the quadratic path is exercised.
    function automatic circle_pair_t random_pair();
        circle_pair_t p;
        int span, vspan, mode;
        mode = $urandom_range(0, 9);
        span = 1 << $urandom_range(2, 15);
        vspan = 1 << $urandom_range(0, 15);
        p.fx = 16'($urandom_range(0, 2 * span) - span);
        p.fy = 16'($urandom_range(0, 2 * span) - span);
        p.sx = 16'($urandom_range(0, 2 * span) - span);
        p.sy = 16'($urandom_range(0, 2 * span) - span);
        p.fvx = 16'($urandom_range(0, 2 * vspan) - vspan);
        p.fvy = 16'($urandom_range(0, 2 * vspan) - vspan);
        p.svx = 16'($urandom_range(0, 2 * vspan) - vspan);
        p.svy = 16'($urandom_range(0, 2 * vspan) - vspan);
        p.fr = 12'($urandom_range(0, span > 4095 ? 4095 : span));
        p.sr = 12'($urandom_range(0, span > 4095 ? 4095 : span));
        if (mode <= 1) begin
            p = {rand16(), rand16(), rand16(), rand16(), rand16(), rand16(),
                 rand16(), rand16(), 12'($urandom), 12'($urandom)};
        end else if (mode <= 7) begin
            p.svx = p.fvx + 16'((p.fx - p.sx) / int'($urandom_range(1, 64)));
            p.svy = p.fvy + 16'((p.fy - p.sy) / int'($urandom_range(1, 64)));
        end else if (mode == 8) begin
            p.svx = p.fvx + 16'($urandom_range(0, 2));
            p.svy = p.fvy;
        end
        return p;
    endfunction

    initial begin
        logic [15:0] margins[6];
        logic [15:0] tols[6];
        stim_row_t row;
        margins = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0};
        tols    = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0};
        margins[4] = 16'($urandom);
        tols[4] = 16'($urandom);
        margins[5] = 16'($urandom_range(0, 300));
        tols[5] = 16'($urandom_range(0, 300));

        // All coordinates equal, with zero or full radii: already touching.
        add_row('0, 16'd0, 16'd0, 1'b1, TOUCHING);
        add_row('{16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                  12'd4095, 12'd4095}, 16'd0, 16'd0, 1'b1, TOUCHING);
        // No relative motion while apart.
        add_row('{16'sd100, 16'sd0, 16'sd0, 16'sd0, 16'sd3, 16'sd3, 16'sd3, 16'sd3,
                  12'd1, 12'd0}, 16'd0, 16'd0, 1'b1, NEVER);
        // Moving apart.
        add_row('{16'sd100, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0,
                  12'd1, 12'd0}, 16'd0, 16'd0, 1'b1, NEVER);
        // Head-on approach at unit speed from distance ten.
        add_row('{16'sd10, 16'sd0, 16'sd0, 16'sd0, -16'sd1, 16'sd0, 16'sd0, 16'sd0,
                  12'd0, 12'd0}, 16'd0, 16'd0, 1'b1, '{32'h000A_0000, 1'b0, 1'b0});
        // Approaching but passing wide: negative discriminant.
        add_row('{16'sd10, 16'sd5, 16'sd0, 16'sd0, -16'sd1, 16'sd0, 16'sd0, 16'sd0,
                  12'd1, 12'd0}, 16'd0, 16'd0, 1'b1, NEVER);
        // Extremes of every field.
        add_row('{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                  16'sh7FFF, 16'sh7FFF, 12'd0, 12'd0}, 16'd0, 16'd0, 1'b0, TOUCHING);
        add_row('{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
                  16'sh8000, 16'sh7FFF, 12'd4095, 12'd4095}, 16'd0, 16'd0, 1'b0, TOUCHING);
        add_row('{16'sh7FFF, 16'sh0000, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0000,
                  16'sh0000, 16'sh0000, 12'd0, 12'd0}, 16'd0, 16'd0, 1'b0, TOUCHING);
        add_row('{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'shFFFF, 16'sh0000,
                  16'sh0000, 16'sh0000, 12'd0, 12'd0}, 16'd0, 16'd0, 1'b0, TOUCHING);
        // Overlap margin at its top: a near miss counts as touching, a wider gap does not.
        add_row('{16'sd100, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                  12'd0, 12'd0}, 16'hFFFF, 16'd0, 1'b1, TOUCHING);
        add_row('{16'sd300, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                  12'd0, 12'd0}, 16'hFFFF, 16'd0, 1'b1, NEVER);
        // Large tolerance: linear case, both directions, and both terms zero.
        add_row('{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'shFFFF, 16'sh0000,
                  16'sh0000, 16'sh0000, 12'd0, 12'd0}, 16'd0, 16'hFFFF, 1'b0, TOUCHING);
        add_row('{16'sh7FFF, 16'sh0000, 16'sh8000, 16'sh0000, 16'sh0001, 16'sh0000,
                  16'sh0000, 16'sh0000, 12'd0, 12'd0}, 16'd0, 16'hFFFF, 1'b1, NEVER);
        add_row('{16'sd100, 16'sd0, 16'sd0, 16'sd0, -16'sd1, 16'sd0, 16'sd0, 16'sd0,
                  12'd0, 12'd0}, 16'd0, 16'hFFFF, 1'b1, NEVER);
        add_row('{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh0000, 16'shFFFF,
                  16'sh0000, 16'sh0000, 12'd0, 12'd0}, 16'd0, 16'h0001, 1'b0, TOUCHING);
        add_row('{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF,
                  16'sh8000, 16'sh8000, 12'd4095, 12'd4095}, 16'hFFFF, 16'hFFFF,
                1'b0, TOUCHING);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n]) begin
            row = directed_rows[n];
            if (row.margin != cur_margin || row.tol != cur_tol) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
                set_config(row.margin, row.tol);
            end
            send_pair(row.pair, row.known, row.result);
        end

        for (int ph = 0; ph < 6; ph++) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
            set_config(margins[ph], tols[ph]);
            for (int n = 0; n < 330; n++)
                send_pair(random_pair(), 1'b0, TOUCHING);
        end
        in_ch.valid <= 1'b0;

        while (expected_contacts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
